>>> rtl/trtd_pkg.sv
// Shared types, widths and codes of the time-tagged record decoder.
package trtd_pkg;

    localparam int TT_W       = 25;
    localparam int CH_W       = 6;
    localparam int NS_W       = 10;
    localparam int DT_W       = 15;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 48;
    localparam int CT_W       = 63;
    localparam int FT_W       = 39;
    localparam int PER_W      = 40;
    localparam int BIN_W      = 25;
    localparam int FSRC_W     = TT_W - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam longint unsigned TRTD_T2_WRAP = 64'd33554432;
    localparam longint unsigned TRTD_T3_WRAP = 64'd1024;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
    localparam int OQ_DEPTH = 8;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [CH_W-1:0] CH_OVF  = CH_W'(63);
    localparam logic [CH_W-1:0] CH_SYNC = CH_W'(0);

    localparam logic [KIND_W-1:0] KIND_PHOTON = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_SYNC   = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_MARKER = KIND_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_MODE_T3     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_T3_AS_T2    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_PERIOD = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_BIN   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LABEL  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_REC_LIMIT   = CFG_IDX_W'(5);

    localparam logic [CT_W-1:0] MAX_CT = {CT_W{1'b1}};
    localparam logic [FT_W-1:0] MAX_FT = {FT_W{1'b1}};

    typedef enum logic [1:0] {
        CLS_PHOTON = 2'd0,
        CLS_SYNC   = 2'd1,
        CLS_MARKER = 2'd2,
        CLS_OVF    = 2'd3
    } t_cls;

    typedef struct packed {
        logic            is_special;
        logic [CH_W-1:0] channel;
        logic [TT_W-1:0] time_tag;
        logic [NS_W-1:0] sync_count;
        logic [DT_W-1:0] delay_bins;
    } t_rec;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   channel_out;
        logic [IDX_W-1:0]  record_index;
        logic [CT_W-1:0]   coarse_time;
        logic [NS_W-1:0]   sync_offset;
        logic [FT_W-1:0]   fine_time;
    } t_res;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CH_W-1:0]   channel_out;
        logic [IDX_W-1:0]  record_index;
        logic [CT_W-1:0]   coarse;
        logic [NS_W-1:0]   sync_offset;
        logic [FSRC_W-1:0] fine_src;
        logic              use_abs;
        logic              use_mul;
    } t_cmd;

    typedef struct packed {
        logic              mode_t3;
        logic              t3_as_t2;
        logic [PER_W-1:0]  sync_period_ps;
        logic [BIN_W-1:0]  delay_bin_ps;
        logic [CH_W-1:0]   sync_channel_label;
        logic [IDX_W-1:0]  record_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode_t3:            1'b0,
        t3_as_t2:           1'b0,
        sync_period_ps:     PER_W'(1),
        delay_bin_ps:       BIN_W'(1),
        sync_channel_label: CH_W'(8),
        record_limit:       {IDX_W{1'b1}}
    };

endpackage

>>> rtl/trtd_fifo.sv
// Small show-ahead queue with occupancy count.
module trtd_fifo import trtd_pkg::*; #(
    parameter int  DEPTH = MQ_DEPTH,
    parameter type T     = t_cmd
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  T                           i_data,
    input  logic                       i_pop,
    output T                           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < CNT_W'(DEPTH))
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a write");
`endif

endmodule

>>> rtl/trtd_front.sv
// Record decode, time base and record counter, command issue to the back end.
module trtd_front import trtd_pkg::*; #(
    parameter longint unsigned T2_WRAP = TRTD_T2_WRAP,
    parameter longint unsigned T3_WRAP = TRTD_T3_WRAP
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_accept,
    input  t_rec                i_rec,
    input  logic [MQ_CNT_W-1:0] i_q_count,
    output logic                o_full,
    output logic                o_q_push,
    output t_cmd                o_q_cmd
);

    localparam int T2_INC_W = TT_W + $clog2(T2_WRAP + 1);
    localparam int T3_INC_W = NS_W + $clog2(T3_WRAP + 1);

    logic                r_a_valid;
    t_rec                r_a_rec;
    t_cls                r_a_cls;
    logic [CT_W-1:0]     r_a_inc;
    logic [CT_W-1:0]     r_time_base;
    logic [IDX_W-1:0]    r_records_seen;

    t_cls                n_cls;
    logic [T2_INC_W-1:0] t2_inc;
    logic [T3_INC_W-1:0] t3_inc;
    logic [CT_W-1:0]     n_inc;
    logic                limit_hit;
    logic                live;
    logic [IDX_W-1:0]    rec_next;
    logic [CT_W:0]       tb_sum;
    logic [CT_W-1:0]     tb_sat;
    logic [CT_W:0]       abs_sum;
    logic [CT_W-1:0]     abs_sat;
    t_cmd                n_cmd;

    assign o_full = ({1'b0, i_q_count} + (MQ_CNT_W + 1)'(r_a_valid))
                    >= (MQ_CNT_W + 1)'(MQ_DEPTH);

    // decode stage
    assign t2_inc = T2_INC_W'(i_rec.time_tag) * T2_INC_W'(T2_WRAP);
    assign t3_inc = T3_INC_W'(i_rec.sync_count) * T3_INC_W'(T3_WRAP);
    assign n_inc  = i_cfg.mode_t3 ? CT_W'(t3_inc) : CT_W'(t2_inc);

    always_comb begin
        if (i_rec.is_special && i_rec.channel == CH_OVF) begin
            n_cls = CLS_OVF;
        end else if (i_rec.is_special && !i_cfg.mode_t3 && i_rec.channel == CH_SYNC) begin
            n_cls = CLS_SYNC;
        end else if (i_rec.is_special) begin
            n_cls = CLS_MARKER;
        end else begin
            n_cls = CLS_PHOTON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_rec <= i_rec;
            r_a_cls <= n_cls;
            r_a_inc <= n_inc;
        end
    end

    // state update and command build
    assign limit_hit = r_records_seen >= i_cfg.record_limit;
    assign live      = r_a_valid && !limit_hit;
    assign rec_next  = r_records_seen + 1'b1;
    assign tb_sum    = {1'b0, r_time_base} + {1'b0, r_a_inc};
    assign tb_sat    = tb_sum[CT_W] ? MAX_CT : tb_sum[CT_W-1:0];
    assign abs_sum   = {1'b0, r_time_base} + (CT_W + 1)'(r_a_rec.sync_count);
    assign abs_sat   = abs_sum[CT_W] ? MAX_CT : abs_sum[CT_W-1:0];

    always_comb begin
        n_cmd = '0;
        case (r_a_cls)
            CLS_PHOTON: begin
                n_cmd.kind         = KIND_PHOTON;
                n_cmd.channel_out  = r_a_rec.channel;
                n_cmd.record_index = rec_next;
                if (i_cfg.mode_t3) begin
                    n_cmd.use_mul  = 1'b1;
                    n_cmd.fine_src = FSRC_W'(r_a_rec.delay_bins);
                    if (i_cfg.t3_as_t2) begin
                        n_cmd.use_abs = 1'b1;
                        n_cmd.coarse  = abs_sat;
                    end else begin
                        n_cmd.coarse      = r_time_base;
                        n_cmd.sync_offset = r_a_rec.sync_count;
                    end
                end else begin
                    n_cmd.coarse   = r_time_base >> 1;
                    n_cmd.fine_src = r_a_rec.time_tag[TT_W-1:1];
                end
            end
            CLS_SYNC: begin
                n_cmd.kind         = KIND_SYNC;
                n_cmd.channel_out  = i_cfg.sync_channel_label;
                n_cmd.record_index = rec_next;
                n_cmd.coarse       = r_time_base >> 1;
                n_cmd.fine_src     = r_a_rec.time_tag[TT_W-1:1];
            end
            CLS_MARKER: begin
                n_cmd.kind        = KIND_MARKER;
                n_cmd.channel_out = r_a_rec.channel;
            end
            default: begin
                n_cmd = '0;
            end
        endcase
    end

    assign o_q_push = live && (r_a_cls != CLS_OVF);
    assign o_q_cmd  = n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_base    <= '0;
            r_records_seen <= '0;
        end else if (live) begin
            case (r_a_cls) inside
                CLS_OVF: begin
                    r_time_base <= tb_sat;
                end
                CLS_PHOTON, CLS_SYNC: begin
                    r_records_seen <= rec_next;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/trtd_back.sv
// Saturating multiply pipeline for T3 delay and absolute sync time.
module trtd_back import trtd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_empty,
    input  t_cmd                i_q_cmd,
    output logic                o_q_pop,
    input  logic [OQ_CNT_W-1:0] i_out_count,
    output logic                o_out_push,
    output t_res                o_out_res
);

    localparam int HALF_W = 32;
    localparam int AHI_W  = CT_W - HALF_W;
    localparam int BHI_W  = PER_W - HALF_W;
    localparam int LL_W   = 2 * HALF_W;
    localparam int LH_W   = HALF_W + BHI_W;
    localparam int HL_W   = AHI_W + HALF_W;
    localparam int HH_W   = AHI_W + BHI_W;
    localparam int MID_W  = LL_W;
    localparam int TOT_W  = MID_W + HALF_W + 1;
    localparam int FP_W   = DT_W + BIN_W;

    logic                r_v1;
    t_cmd                r_s1_cmd;
    logic [LL_W-1:0]     r_pp_ll;
    logic [LH_W-1:0]     r_pp_lh;
    logic [HL_W-1:0]     r_pp_hl;
    logic [HH_W-1:0]     r_pp_hh;
    logic [FP_W-1:0]     r_fine_prod;

    logic                r_v2;
    t_cmd                r_s2_cmd;
    logic [MID_W-1:0]    r_mid;
    logic [LL_W-1:0]     r_ll;
    logic                r_hh_nz;
    logic [FT_W-1:0]     r_fine;

    logic                take;
    logic [HALF_W-1:0]   a_lo;
    logic [AHI_W-1:0]    a_hi;
    logic [HALF_W-1:0]   b_lo;
    logic [BHI_W-1:0]    b_hi;
    logic [TOT_W-1:0]    total;
    logic                coarse_sat;
    logic [CT_W-1:0]     coarse_out;

    // pull only when the output queue has room for everything in flight
    assign take = !i_q_empty &&
                  (({1'b0, i_out_count} + (OQ_CNT_W + 1)'(r_v1) + (OQ_CNT_W + 1)'(r_v2))
                   < (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign o_q_pop = take;

    assign a_lo = i_q_cmd.coarse[HALF_W-1:0];
    assign a_hi = i_q_cmd.coarse[CT_W-1:HALF_W];
    assign b_lo = i_cfg.sync_period_ps[HALF_W-1:0];
    assign b_hi = i_cfg.sync_period_ps[PER_W-1:HALF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= take;
            r_v2 <= r_v1;
        end
    end

    // stage 1: partial products
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_cmd    <= i_q_cmd;
            r_pp_ll     <= LL_W'(a_lo) * LL_W'(b_lo);
            r_pp_lh     <= LH_W'(a_lo) * LH_W'(b_hi);
            r_pp_hl     <= HL_W'(a_hi) * HL_W'(b_lo);
            r_pp_hh     <= HH_W'(a_hi) * HH_W'(b_hi);
            r_fine_prod <= FP_W'(i_q_cmd.fine_src[DT_W-1:0]) * FP_W'(i_cfg.delay_bin_ps);
        end
    end

    // stage 2: middle sum, fine saturation
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_s2_cmd <= r_s1_cmd;
            r_mid    <= MID_W'(r_pp_lh) + MID_W'(r_pp_hl);
            r_ll     <= r_pp_ll;
            r_hh_nz  <= (r_pp_hh != '0);
            r_fine   <= (r_fine_prod[FP_W-1:FT_W] != '0) ? MAX_FT : r_fine_prod[FT_W-1:0];
        end
    end

    // final sum and coarse saturation
    assign total      = TOT_W'({r_mid, {HALF_W{1'b0}}}) + TOT_W'(r_ll);
    assign coarse_sat = r_hh_nz || (total[TOT_W-1:CT_W] != '0);
    assign coarse_out = r_s2_cmd.use_abs ? (coarse_sat ? MAX_CT : total[CT_W-1:0])
                                         : r_s2_cmd.coarse;

    assign o_out_push            = r_v2;
    assign o_out_res.kind         = r_s2_cmd.kind;
    assign o_out_res.channel_out  = r_s2_cmd.channel_out;
    assign o_out_res.record_index = r_s2_cmd.record_index;
    assign o_out_res.coarse_time  = coarse_out;
    assign o_out_res.sync_offset  = r_s2_cmd.sync_offset;
    assign o_out_res.fine_time    = r_s2_cmd.use_mul ? r_fine : FT_W'(r_s2_cmd.fine_src);

endmodule

>>> rtl/tttr_record_time_decoder.sv
// Top level of the time-tagged record decoder: config registers, front, queues, back.
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------------
//  records   push / full            i_rec   (is_special, channel, time_tag, ...)
//  results   pop / empty            o_res   (kind, channel_out, record_index, ...)
//  config    i_cfg_we               i_cfg_idx, i_cfg_data
//
// One request is taken per cycle while full is low; a result reaches o_res through the
// decode register, the command queue, two multiply stages and the result queue.
// Overflow records and records past the limit give no result.
// Synchronous reset clears the time base, record count and queues and loads the
// register defaults. full rises when the command queue plus the decode stage hold
// four commands; the back end stops pulling when the result queue plus its two
// multiply stages would exceed eight.
module tttr_record_time_decoder import trtd_pkg::*; #(
    parameter longint unsigned T2_WRAP = TRTD_T2_WRAP,
    parameter longint unsigned T3_WRAP = TRTD_T3_WRAP
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_rec                  i_rec,
    output logic                  empty,
    input  logic                  pop,
    output t_res                  o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                r_cfg;
    logic                accept;
    logic                mq_push;
    t_cmd                mq_wdata;
    t_cmd                mq_rdata;
    logic                mq_pop;
    logic                mq_empty;
    logic [MQ_CNT_W-1:0] mq_count;
    logic                oq_push;
    t_res                oq_wdata;
    logic                oq_empty;
    logic [OQ_CNT_W-1:0] oq_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE_T3:     r_cfg.mode_t3            <= i_cfg_data[0];
                REG_T3_AS_T2:    r_cfg.t3_as_t2           <= i_cfg_data[0];
                REG_SYNC_PERIOD: r_cfg.sync_period_ps     <= i_cfg_data[PER_W-1:0];
                REG_DELAY_BIN:   r_cfg.delay_bin_ps       <= i_cfg_data[BIN_W-1:0];
                REG_SYNC_LABEL:  r_cfg.sync_channel_label <= i_cfg_data[CH_W-1:0];
                REG_REC_LIMIT:   r_cfg.record_limit       <= i_cfg_data[IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept = push && !full;

    trtd_front #(
        .T2_WRAP (T2_WRAP),
        .T3_WRAP (T3_WRAP)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (accept),
        .i_rec     (i_rec),
        .i_q_count (mq_count),
        .o_full    (full),
        .o_q_push  (mq_push),
        .o_q_cmd   (mq_wdata)
    );

    trtd_fifo #(
        .DEPTH (MQ_DEPTH),
        .T     (t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mq_push),
        .i_data  (mq_wdata),
        .i_pop   (mq_pop),
        .o_data  (mq_rdata),
        .o_empty (mq_empty),
        .o_count (mq_count)
    );

    trtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (mq_empty),
        .i_q_cmd     (mq_rdata),
        .o_q_pop     (mq_pop),
        .i_out_count (oq_count),
        .o_out_push  (oq_push),
        .o_out_res   (oq_wdata)
    );

    trtd_fifo #(
        .DEPTH (OQ_DEPTH),
        .T     (t_res)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_wdata),
        .i_pop   (pop && !oq_empty),
        .o_data  (o_res),
        .o_empty (oq_empty),
        .o_count (oq_count)
    );

    assign empty = oq_empty;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for tttr_record_time_decoder: directed table, random phases, checker.
`timescale 1ns / 100ps

module tb_top;
    import trtd_pkg::*;

    localparam logic [PER_W-1:0] PERIOD_TOP = PER_W'(64'd1000000000000);
    localparam logic [BIN_W-1:0] BIN_TOP    = BIN_W'(16777216);
    localparam int SETTLE_CYCLES  = 8;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int BASE_OVERFLOWS = 40;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REC,
        ROW_NONE,
        ROW_EXP
    } t_row_op;

    typedef struct {
        t_row_op               op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_rec                  rec;
        t_res                  res;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_rec                  i_rec;
    logic                  empty;
    logic                  pop = 1'b0;
    t_res                  o_res;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state and register shadow
    t_cfg             cfg_sh;
    logic [CT_W-1:0]  time_base;
    logic [IDX_W-1:0] rec_count;

    t_res pending_res[$];
    t_row dir_rows[$];
    int   mismatches     = 0;
    int   results_seen   = 0;
    int   records_sent   = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left      = 0;

    tttr_record_time_decoder dut (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_rec,
        .empty,
        .pop,
        .o_res,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [CT_W-1:0] add_sat63(logic [CT_W-1:0] a, logic [63:0] b);
        logic [64:0] sum;
        sum = 65'(a) + 65'(b);
        return (sum > 65'(MAX_CT)) ? MAX_CT : sum[CT_W-1:0];
    endfunction

    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, logic [63:0] top);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return (prod > 128'(top)) ? top : prod[63:0];
    endfunction

    function automatic bit decode_record(input t_rec r, output t_res res);
        logic [CT_W-1:0] abs_sync;
        res = '0;
        if (rec_count >= cfg_sh.record_limit)
            return 1'b0;
        if (r.is_special && r.channel == CH_OVF) begin
            if (!cfg_sh.mode_t3)
                time_base = add_sat63(time_base, 64'(r.time_tag) * TRTD_T2_WRAP);
            else
                time_base = add_sat63(time_base, 64'(r.sync_count) * TRTD_T3_WRAP);
            return 1'b0;
        end
        if (r.is_special && !(r.channel == CH_SYNC && !cfg_sh.mode_t3)) begin
            res.kind        = KIND_MARKER;
            res.channel_out = r.channel;
            return 1'b1;
        end
        rec_count        = rec_count + 1'b1;
        res.record_index = rec_count;
        if (!cfg_sh.mode_t3) begin
            res.kind        = r.is_special ? KIND_SYNC : KIND_PHOTON;
            res.channel_out = r.is_special ? cfg_sh.sync_channel_label : r.channel;
            res.coarse_time = time_base >> 1;
            res.fine_time   = FT_W'(r.time_tag >> 1);
            return 1'b1;
        end
        res.kind        = KIND_PHOTON;
        res.channel_out = r.channel;
        res.fine_time   = FT_W'(mul_sat(64'(r.delay_bins), 64'(cfg_sh.delay_bin_ps),
                                        64'(MAX_FT)));
        if (cfg_sh.t3_as_t2) begin
            abs_sync        = add_sat63(time_base, 64'(r.sync_count));
            res.coarse_time = CT_W'(mul_sat(64'(abs_sync), 64'(cfg_sh.sync_period_ps),
                                            64'(MAX_CT)));
        end else begin
            res.coarse_time = time_base;
            res.sync_offset = r.sync_count;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (pending_res.size() == 0) begin
                $error("unexpected result: %p", o_res);
                mismatches++;
            end else begin
                want = pending_res.pop_front();
                check_field("kind", 64'(want.kind), 64'(o_res.kind));
                check_field("channel_out", 64'(want.channel_out), 64'(o_res.channel_out));
                check_field("record_index", 64'(want.record_index), 64'(o_res.record_index));
                check_field("coarse_time", 64'(want.coarse_time), 64'(o_res.coarse_time));
                check_field("sync_offset", 64'(want.sync_offset), 64'(o_res.sync_offset));
                check_field("fine_time", 64'(want.fine_time), 64'(o_res.fine_time));
            end
        end
    end

    // result side: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_rec mk_rec(logic sp, logic [CH_W-1:0] ch, logic [TT_W-1:0] tt,
                                    logic [NS_W-1:0] ns, logic [DT_W-1:0] dt);
        return '{is_special: sp, channel: ch, time_tag: tt, sync_count: ns, delay_bins: dt};
    endfunction

    function automatic t_res mk_res(logic [KIND_W-1:0] kind, logic [CH_W-1:0] ch,
                                    logic [IDX_W-1:0] idx, logic [CT_W-1:0] ct,
                                    logic [NS_W-1:0] so, logic [FT_W-1:0] ft);
        return '{kind: kind, channel_out: ch, record_index: idx, coarse_time: ct,
                 sync_offset: so, fine_time: ft};
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        return '{op: ROW_CFG, idx: idx, data: data, rec: '0, res: '0};
    endfunction

    function automatic t_row rec_row(t_row_op op, t_rec r, t_res e = '0);
        return '{op: op, idx: '0, data: '0, rec: r, res: e};
    endfunction

    function automatic t_rec rand_record();
        t_rec        r;
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom, $urandom};
        r    = raw[$bits(t_rec)-1:0];
        pick = $urandom_range(99);
        if (pick < 12) begin
            r.is_special = 1'b1;
            r.channel    = CH_OVF;
            if ($urandom_range(4) != 0)
                r.time_tag = TT_W'($urandom_range(3));
        end else if (pick < 22) begin
            r.is_special = 1'b1;
            r.channel    = CH_SYNC;
        end else if (pick < 32) begin
            r.is_special = 1'b1;
            r.channel    = CH_W'($urandom_range(62));
        end else begin
            r.is_special = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale(int width, logic [CFG_DATA_W-1:0] top);
        logic [CFG_DATA_W-1:0] mask;
        mask = (48'd1 << width) - 1'b1;
        case ($urandom_range(5))
            0: return 48'd1;
            1: return 48'($urandom_range(1, 1000));
            2: return top;
            3: return mask;
            4: return 48'd0;
            default: return {$urandom, $urandom} & mask;
        endcase
    endfunction

    task automatic send_record(input t_rec r, input t_row_op how = ROW_REC,
                               input t_res typed = '0);
        t_res got;
        bit   some;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push  <= 1'b1;
        i_rec <= r;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        some = decode_record(r, got);
        records_sent++;
        if (how == ROW_EXP)
            pending_res.push_back(typed);
        else if (how == ROW_REC && some)
            pending_res.push_back(got);
    endtask

    // drop push, wait for every pending result, then let in-flight records clear
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE_T3:     cfg_sh.mode_t3            = data[0];
            REG_T3_AS_T2:    cfg_sh.t3_as_t2           = data[0];
            REG_SYNC_PERIOD: cfg_sh.sync_period_ps     = data[PER_W-1:0];
            REG_DELAY_BIN:   cfg_sh.delay_bin_ps       = data[BIN_W-1:0];
            REG_SYNC_LABEL:  cfg_sh.sync_channel_label = data[CH_W-1:0];
            REG_REC_LIMIT:   cfg_sh.record_limit       = data[IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_random(input bit limit_phase);
        settle();
        write_reg(REG_MODE_T3, 48'($urandom_range(1)));
        write_reg(REG_T3_AS_T2, 48'($urandom_range(1)));
        write_reg(REG_SYNC_PERIOD, pick_scale(PER_W, 48'(PERIOD_TOP)));
        write_reg(REG_DELAY_BIN, pick_scale(BIN_W, 48'(BIN_TOP)));
        write_reg(REG_SYNC_LABEL, 48'($urandom_range(63)));
        write_reg(REG_REC_LIMIT, limit_phase ? rec_count + 48'($urandom_range(5, 60)) : '1);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_rec      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        cfg_sh     = CFG_RESET;
        time_base  = '0;
        rec_count  = '0;

        // T2 layout at reset defaults
        dir_rows.push_back(rec_row(ROW_EXP, mk_rec(0, 5, 0, 0, 0),
                                   mk_res(KIND_PHOTON, 5, 1, 0, 0, 0)));
        dir_rows.push_back(rec_row(ROW_EXP, mk_rec(0, 63, '1, '1, '1),
                                   mk_res(KIND_PHOTON, 63, 2, 0, 0, 39'hFFFFFF)));
        dir_rows.push_back(rec_row(ROW_EXP, mk_rec(1, CH_SYNC, 100, 0, 0),
                                   mk_res(KIND_SYNC, 8, 3, 0, 0, 50)));
        dir_rows.push_back(rec_row(ROW_EXP, mk_rec(1, 1, 0, 0, 0),
                                   mk_res(KIND_MARKER, 1, 0, 0, 0, 0)));
        dir_rows.push_back(rec_row(ROW_EXP, mk_rec(1, 62, '1, '1, '1),
                                   mk_res(KIND_MARKER, 62, 0, 0, 0, 0)));
        dir_rows.push_back(rec_row(ROW_NONE, mk_rec(1, CH_OVF, 1, 0, 0)));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(0, 0, 3, 0, 0)));
        dir_rows.push_back(rec_row(ROW_NONE, mk_rec(1, CH_OVF, '1, '1, '1)));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(1, CH_SYNC, 7, 0, 0)));
        dir_rows.push_back(cfg_row(REG_SYNC_LABEL, 63));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(1, CH_SYNC, '1, 0, 0)));
        dir_rows.push_back(cfg_row(REG_SYNC_LABEL, 0));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(1, CH_SYNC, 2, 0, 0)));
        // T3 raw
        dir_rows.push_back(cfg_row(REG_MODE_T3, 1));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(0, 7, '1, '1, '1)));
        dir_rows.push_back(rec_row(ROW_EXP, mk_rec(1, CH_SYNC, '1, '1, '1),
                                   mk_res(KIND_MARKER, 0, 0, 0, 0, 0)));
        dir_rows.push_back(rec_row(ROW_NONE, mk_rec(1, CH_OVF, 0, '1, 0)));
        dir_rows.push_back(rec_row(ROW_NONE, mk_rec(1, CH_OVF, '1, 0, '1)));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(0, 0, 0, 0, 0)));
        // T3 absolute: top of range, saturating, and zero scales
        dir_rows.push_back(cfg_row(REG_T3_AS_T2, 1));
        dir_rows.push_back(cfg_row(REG_SYNC_PERIOD, 48'(PERIOD_TOP)));
        dir_rows.push_back(cfg_row(REG_DELAY_BIN, 48'(BIN_TOP)));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(0, 9, 0, '1, '1)));
        dir_rows.push_back(cfg_row(REG_SYNC_PERIOD, 48'hFF_FFFF_FFFF));
        dir_rows.push_back(cfg_row(REG_DELAY_BIN, 48'h1FF_FFFF));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(0, 10, 0, '1, '1)));
        dir_rows.push_back(cfg_row(REG_SYNC_PERIOD, 0));
        dir_rows.push_back(cfg_row(REG_DELAY_BIN, 0));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(0, 11, 0, 5, 5)));
        // limit of zero stops everything, overflows included
        dir_rows.push_back(cfg_row(REG_REC_LIMIT, 0));
        dir_rows.push_back(rec_row(ROW_NONE, mk_rec(0, 12, 0, 1, 1)));
        dir_rows.push_back(rec_row(ROW_NONE, mk_rec(1, 3, 0, 0, 0)));
        dir_rows.push_back(rec_row(ROW_NONE, mk_rec(1, CH_OVF, 0, '1, 0)));
        dir_rows.push_back(cfg_row(REG_REC_LIMIT, '1));
        dir_rows.push_back(cfg_row(REG_T3_AS_T2, 0));
        dir_rows.push_back(rec_row(ROW_REC, mk_rec(0, 13, 0, 2, 2)));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_record(dir_rows[i].rec, dir_rows[i].op, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            cfg_random(ph == 5);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            repeat (PHASE_ITEMS) send_record(rand_record());
            if (ph == 3) begin
                // back-pressure: long pop hold-off while requests keep coming
                settle();
                write_reg(REG_REC_LIMIT, '1);
                send_idle_pct = 0;
                hold_left     = 300;
                repeat (40) send_record(rand_record());
            end
        end

        // push the time base high, then look at every layout
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_MODE_T3, 0);
        write_reg(REG_REC_LIMIT, '1);
        repeat (BASE_OVERFLOWS) send_record(mk_rec(1, CH_OVF, '1, 0, 0));
        repeat (4) send_record(mk_rec(0, CH_W'($urandom), TT_W'($urandom), 0, 0));
        send_record(mk_rec(1, CH_SYNC, '1, 0, 0));
        settle();
        write_reg(REG_MODE_T3, 1);
        write_reg(REG_T3_AS_T2, 1);
        write_reg(REG_SYNC_PERIOD, 48'(PERIOD_TOP));
        repeat (4) send_record(mk_rec(0, 1, 0, NS_W'($urandom), DT_W'($urandom)));
        send_record(mk_rec(1, CH_OVF, 0, '1, 0));
        settle();
        write_reg(REG_T3_AS_T2, 0);
        repeat (4) send_record(mk_rec(0, 2, 0, NS_W'($urandom), DT_W'($urandom)));

        settle();
        $display("Sent %0d records, checked %0d results over T2, T3 raw and T3 absolute",
                 records_sent, results_seen);
        $display("layouts, with record limits, back-pressure and a large time base.");
        if (mismatches == 0 && pending_res.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/trtd_pkg.sv
rtl/trtd_fifo.sv
rtl/trtd_front.sv
rtl/trtd_back.sv
rtl/tttr_record_time_decoder.sv
tb/tb_top.sv
